// ===== design/spi_nor_flash_command_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the command sequencer modules.
// ----------------------------------------------------------------------------
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Item types, result codes, flash opcodes and the job descriptor that passes
// from the front end to the back end.
// ----------------------------------------------------------------------------
package sfcs_pkg;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [23:0] address;
      logic [15:0] count;
      logic [7:0]  data_byte;
   } sfcs_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  spi_byte;
      logic        need_reply;
      logic [23:0] host_data;
      logic        last;
   } sfcs_rsp_type;

   localparam logic [2:0] REQ_READ_ID     = 3'd0;
   localparam logic [2:0] REQ_ERASE       = 3'd1;
   localparam logic [2:0] REQ_WRITE_START = 3'd2;
   localparam logic [2:0] REQ_WRITE_DATA  = 3'd3;
   localparam logic [2:0] REQ_READ_START  = 3'd4;
   localparam logic [2:0] REQ_RX_BYTE     = 3'd5;

   localparam logic [2:0] KIND_SPI     = 3'd0;
   localparam logic [2:0] KIND_RELEASE = 3'd1;
   localparam logic [2:0] KIND_HOST    = 3'd2;
   localparam logic [2:0] KIND_DONE    = 3'd3;
   localparam logic [2:0] KIND_REJECT  = 3'd4;

   localparam logic [7:0] OP_WREN   = 8'h06;
   localparam logic [7:0] OP_RDSR   = 8'h05;
   localparam logic [7:0] OP_READ   = 8'h03;
   localparam logic [7:0] OP_PROG   = 8'h02;
   localparam logic [7:0] OP_ERASE  = 8'h20;
   localparam logic [7:0] OP_RDID   = 8'h9F;
   localparam logic [7:0] BUSY_MASK = 8'h01;
   localparam logic [7:0] FILL_BYTE = 8'hFF;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      JOB_READ_ID,
      JOB_ERASE,
      JOB_DONE,
      JOB_REJECT,
      JOB_READ_START,
      JOB_WRITE_DATA,
      JOB_FILL,
      JOB_ID_DONE,
      JOB_POLL_END,
      JOB_READ_BYTE
   } sfcs_job_kind_type;

   typedef struct packed {
      sfcs_job_kind_type kind;
      logic [23:0]       address;
      logic [23:0]       value;
      logic              open_frame;
      logic              poll;
      logic              more;
   } sfcs_job_type;

endpackage

// ===== design/sfcs_front.sv =====
// ----------------------------------------------------------------------------
// Command sequencer front end
// Accepts request items, checks them against the operation mode, updates the
// operation state and queues at most one job descriptor for the back end.
// ----------------------------------------------------------------------------
module sfcs_front
   import sfcs_pkg::*;
#(
   parameter int PAGE_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sfcs_req_type req_data,
   input  logic         queue_full,
   output logic         push,
   output sfcs_job_type push_job
);

   localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ID,
      MODE_ERASE_POLL,
      MODE_WRITE,
      MODE_WRITE_POLL,
      MODE_READ
   } mode_type;

   mode_type     mode_ff, mode_in;
   logic [23:0]  addr_ff, addr_in;
   logic [15:0]  left_ff, left_in;
   logic [23:0]  id_acc_ff, id_acc_in;
   logic [1:0]   id_seen_ff, id_seen_in;
   logic         frame_open_ff, frame_open_in;
   logic         want_push;
   logic         accept;
   logic [23:0]  addr_inc;
   logic [15:0]  left_dec;
   logic [23:0]  acc_new;
   logic [1:0]   seen_new;
   sfcs_job_type job;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && want_push;
   assign push_job  = job;
   assign addr_inc  = addr_ff + 24'd1;
   assign left_dec  = left_ff - 16'd1;
   assign acc_new   = {id_acc_ff[15:0], req_data.data_byte};
   assign seen_new  = id_seen_ff + 2'd1;

   always_comb begin
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      left_in       = left_ff;
      id_acc_in     = id_acc_ff;
      id_seen_in    = id_seen_ff;
      frame_open_in = frame_open_ff;
      want_push     = 1'b1;
      job           = '0;
      job.kind      = JOB_REJECT;
      priority if (mode_ff == MODE_IDLE && req_data.req_type == REQ_READ_ID) begin
         id_acc_in  = '0;
         id_seen_in = '0;
         job.kind   = JOB_READ_ID;
         mode_in    = MODE_ID;
      end else if (mode_ff == MODE_IDLE && req_data.req_type == REQ_ERASE) begin
         job.kind    = JOB_ERASE;
         job.address = req_data.address;
         mode_in     = MODE_ERASE_POLL;
      end else if (mode_ff == MODE_IDLE && req_data.req_type == REQ_WRITE_START) begin
         if (req_data.count == 16'd0) begin
            job.kind = JOB_DONE;
         end else begin
            want_push     = 1'b0;
            addr_in       = req_data.address;
            left_in       = req_data.count;
            frame_open_in = 1'b0;
            mode_in       = MODE_WRITE;
         end
      end else if (mode_ff == MODE_IDLE && req_data.req_type == REQ_READ_START) begin
         job.kind    = JOB_READ_START;
         job.address = req_data.address;
         job.more    = (req_data.count != 16'd0);
         if (req_data.count != 16'd0) begin
            addr_in = req_data.address;
            left_in = req_data.count;
            mode_in = MODE_READ;
         end
      end else if (mode_ff == MODE_WRITE && req_data.req_type == REQ_WRITE_DATA) begin
         job.kind       = JOB_WRITE_DATA;
         job.address    = addr_ff;
         job.value      = {16'd0, req_data.data_byte};
         job.open_frame = !frame_open_ff;
         job.poll       = (left_dec == 16'd0) || (addr_inc[PAGE_LOG2-1:0] == '0);
         addr_in        = addr_inc;
         left_in        = left_dec;
         frame_open_in  = !job.poll;
         if (job.poll) begin
            mode_in = MODE_WRITE_POLL;
         end
      end else if (mode_ff == MODE_ID && req_data.req_type == REQ_RX_BYTE) begin
         id_acc_in  = acc_new;
         id_seen_in = seen_new;
         if (seen_new != 2'd3) begin
            job.kind = JOB_FILL;
         end else begin
            job.kind  = JOB_ID_DONE;
            job.value = acc_new;
            mode_in   = MODE_IDLE;
         end
      end else if ((mode_ff == MODE_ERASE_POLL || mode_ff == MODE_WRITE_POLL)
                   && req_data.req_type == REQ_RX_BYTE) begin
         if ((req_data.data_byte & BUSY_MASK) != 8'd0) begin
            job.kind = JOB_FILL;
         end else begin
            job.kind = JOB_POLL_END;
            job.more = (mode_ff == MODE_WRITE_POLL) && (left_ff != 16'd0);
            mode_in  = job.more ? MODE_WRITE : MODE_IDLE;
         end
      end else if (mode_ff == MODE_READ && req_data.req_type == REQ_RX_BYTE) begin
         job.kind  = JOB_READ_BYTE;
         job.value = {16'd0, req_data.data_byte};
         job.more  = (left_dec != 16'd0);
         addr_in   = addr_inc;
         left_in   = left_dec;
         if (left_dec == 16'd0) begin
            mode_in = MODE_IDLE;
         end
      end else begin
         job.kind = JOB_REJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         addr_ff       <= '0;
         left_ff       <= '0;
         id_acc_ff     <= '0;
         id_seen_ff    <= '0;
         frame_open_ff <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         addr_ff       <= addr_in;
         left_ff       <= left_in;
         id_acc_ff     <= id_acc_in;
         id_seen_ff    <= id_seen_in;
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

// ===== design/sfcs_queue.sv =====
// ----------------------------------------------------------------------------
// Command sequencer job queue
// Short first-in first-out buffer of job descriptors between the front end
// and the back end.
// ----------------------------------------------------------------------------
module sfcs_queue
   import sfcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  sfcs_job_type push_job,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output sfcs_job_type head_job
);

`include "spi_nor_flash_command_sequencer_unit_assert.svh"

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   sfcs_job_type     entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   `SFCS_ASSERT_SAME(a_no_overflow, clock, reset, push, !full, "Job pushed into a full queue.")
   `SFCS_ASSERT_SAME(a_no_underflow, clock, reset, pop, head_valid, "Job popped from an empty queue.")
   `SFCS_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, count_ff <= CNT_FULL, "Queue count beyond its depth.")

endmodule

// ===== design/sfcs_back.sv =====
// ----------------------------------------------------------------------------
// Command sequencer back end
// Expands the job at the head of the queue into result items, one per cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module sfcs_back
   import sfcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  sfcs_job_type job,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sfcs_rsp_type rsp_data
);

`include "spi_nor_flash_command_sequencer_unit_assert.svh"

   logic [3:0]   step_ff, step_in;
   logic [3:0]   vs;
   logic [3:0]   end_vs;
   logic         is_last;
   logic         issue;
   logic         rsp_valid_ff, rsp_valid_in;
   sfcs_rsp_type rsp_data_ff;
   sfcs_rsp_type res;

   function automatic sfcs_rsp_type spi_item(input logic [7:0] b, input logic reply);
      sfcs_rsp_type t;
      t            = '0;
      t.kind       = KIND_SPI;
      t.spi_byte   = b;
      t.need_reply = reply;
      return t;
   endfunction

   function automatic sfcs_rsp_type kind_item(input logic [2:0] k);
      sfcs_rsp_type t;
      t      = '0;
      t.kind = k;
      return t;
   endfunction

   function automatic sfcs_rsp_type host_item(input logic [23:0] v);
      sfcs_rsp_type t;
      t           = '0;
      t.kind      = KIND_HOST;
      t.host_data = v;
      return t;
   endfunction

   function automatic sfcs_rsp_type addr_item(input logic [23:0] a, input logic [3:0] sel);
      sfcs_rsp_type t;
      logic [1:0]   s;
      s = sel[1:0];
      unique case (s)
         2'd0:    t = spi_item(a[23:16], 1'b0);
         2'd1:    t = spi_item(a[15:8], 1'b0);
         default: t = spi_item(a[7:0], 1'b0);
      endcase
      return t;
   endfunction

   assign issue   = job_valid && (!rsp_valid_ff || rsp_ready);
   assign is_last = (vs == end_vs);
   assign pop     = issue && is_last;

   always_comb begin
      vs     = step_ff;
      end_vs = 4'd0;
      res    = kind_item(KIND_REJECT);
      unique case (job.kind)
         JOB_READ_ID: begin
            end_vs = 4'd1;
            res    = (vs == 4'd0) ? spi_item(OP_RDID, 1'b0) : spi_item(FILL_BYTE, 1'b1);
         end
         JOB_ERASE: begin
            end_vs = 4'd8;
            unique case (vs)
               4'd0:             res = spi_item(OP_WREN, 1'b0);
               4'd1:             res = kind_item(KIND_RELEASE);
               4'd2:             res = spi_item(OP_ERASE, 1'b0);
               4'd3, 4'd4, 4'd5: res = addr_item(job.address, vs - 4'd3);
               4'd6:             res = kind_item(KIND_RELEASE);
               4'd7:             res = spi_item(OP_RDSR, 1'b0);
               default:          res = spi_item(FILL_BYTE, 1'b1);
            endcase
         end
         JOB_DONE: begin
            res = kind_item(KIND_DONE);
         end
         JOB_REJECT: begin
            res = kind_item(KIND_REJECT);
         end
         JOB_READ_START: begin
            end_vs = job.more ? 4'd4 : 4'd5;
            unique case (vs)
               4'd0:             res = spi_item(OP_READ, 1'b0);
               4'd1, 4'd2, 4'd3: res = addr_item(job.address, vs - 4'd1);
               4'd4:             res = job.more ? spi_item(FILL_BYTE, 1'b1)
                                                : kind_item(KIND_RELEASE);
               default:          res = kind_item(KIND_DONE);
            endcase
         end
         JOB_WRITE_DATA: begin
            vs     = job.open_frame ? step_ff : step_ff + 4'd6;
            end_vs = job.poll ? 4'd9 : 4'd6;
            unique case (vs)
               4'd0:             res = spi_item(OP_WREN, 1'b0);
               4'd1:             res = kind_item(KIND_RELEASE);
               4'd2:             res = spi_item(OP_PROG, 1'b0);
               4'd3, 4'd4, 4'd5: res = addr_item(job.address, vs - 4'd3);
               4'd6:             res = spi_item(job.value[7:0], 1'b0);
               4'd7:             res = kind_item(KIND_RELEASE);
               4'd8:             res = spi_item(OP_RDSR, 1'b0);
               default:          res = spi_item(FILL_BYTE, 1'b1);
            endcase
         end
         JOB_FILL: begin
            res = spi_item(FILL_BYTE, 1'b1);
         end
         JOB_ID_DONE: begin
            end_vs = 4'd2;
            unique case (vs)
               4'd0:    res = kind_item(KIND_RELEASE);
               4'd1:    res = host_item(job.value);
               default: res = kind_item(KIND_DONE);
            endcase
         end
         JOB_POLL_END: begin
            end_vs = job.more ? 4'd0 : 4'd1;
            res    = (vs == 4'd0) ? kind_item(KIND_RELEASE) : kind_item(KIND_DONE);
         end
         JOB_READ_BYTE: begin
            end_vs = job.more ? 4'd1 : 4'd2;
            unique case (vs)
               4'd0:    res = host_item(job.value);
               4'd1:    res = job.more ? spi_item(FILL_BYTE, 1'b1)
                                       : kind_item(KIND_RELEASE);
               default: res = kind_item(KIND_DONE);
            endcase
         end
         default: begin
            res = kind_item(KIND_REJECT);
         end
      endcase
      res.last = (vs == end_vs);
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (issue) begin
         step_in      = is_last ? 4'd0 : step_ff + 4'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SFCS_ASSERT_SAME(a_step_has_job, clock, reset, step_ff != 4'd0, job_valid, "Job left the queue before its last result.")
   `SFCS_ASSERT_NEXT(a_step_advances, clock, reset, issue && !is_last, step_ff != 4'd0, "Job position failed to advance.")
   `SFCS_ASSERT_SAME(a_clean_fields, clock, reset, rsp_valid_ff && rsp_data_ff.kind != KIND_SPI, rsp_data_ff.spi_byte == 8'd0 && !rsp_data_ff.need_reply, "Serial byte fields set on a non-byte result.")

endmodule

// ===== design/spi_nor_flash_command_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Master-side sequencer that turns host requests into chip-select framed
// command bytes for a serial NOR flash: identifier read, sector erase, paged
// buffered write with status polling, and read.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_ready   sfcs_req_type
//   rsp_      out         rsp_valid/rsp_ready   sfcs_rsp_type
//
// A request is taken whenever the job queue has room, so items may arrive
// back to back. The back end emits one result per cycle while the result
// stage is not stalled, and an item yields from none (a write start with a
// non-zero count) up to ten results (a write byte that opens a program frame
// and ends a page). The two-entry job queue and the registered result stage
// let either side stall without the other.
// Reset clears the operation state, the queue and the result stage at once.
// PAGE_BYTES must be a power of two.
module spi_nor_flash_command_sequencer_unit
   import sfcs_pkg::*;
#(
   parameter int PAGE_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sfcs_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sfcs_rsp_type rsp_data
);

   logic         queue_full;
   logic         push;
   sfcs_job_type push_job;
   logic         pop;
   logic         head_valid;
   sfcs_job_type head_job;

   sfcs_front #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   sfcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sfcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/tb_spi_nor_flash_command_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer testbench
// Drives host requests and flash reply bytes into the sequencer, mostly as
// well-formed operations with random content and some stray requests. It
// predicts every framed byte, release, host word and completion, and checks
// each result item in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_spi_nor_flash_command_sequencer_unit;
   import sfcs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PAGE_BYTES     = 256;
   localparam int          RANDOM_ITEMS   = 460;
   localparam int          STALL_LIMIT    = 5000;
   localparam int          TAIL_CYCLES    = 40;
   localparam logic [2:0]  REQ_SPARE_LOW  = 3'd6;
   localparam logic [2:0]  REQ_SPARE_HIGH = 3'd7;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ID_REPLY,
      MODE_ERASE_POLL,
      MODE_WRITE_DATA,
      MODE_WRITE_POLL,
      MODE_READ_REPLY
   } flash_mode_type;

   class flash_frame_board;
      flash_mode_type mode        = MODE_IDLE;
      logic [23:0]    cursor      = '0;
      logic [15:0]    remaining   = '0;
      logic [23:0]    id_value    = '0;
      logic [1:0]     id_seen     = '0;
      bit             frame_open  = 1'b0;
      sfcs_rsp_type   frames_due[$];
      int unsigned    fault_count = 0;

      function void add_result(logic [2:0] kind, logic [7:0] spi, logic reply,
                               logic [23:0] host);
         sfcs_rsp_type r;
         r.kind       = kind;
         r.spi_byte   = spi;
         r.need_reply = reply;
         r.host_data  = host;
         r.last       = 1'b0;
         frames_due.push_back(r);
      endfunction

      function void add_address(logic [23:0] a);
         add_result(KIND_SPI, a[23:16], 1'b0, '0);
         add_result(KIND_SPI, a[15:8], 1'b0, '0);
         add_result(KIND_SPI, a[7:0], 1'b0, '0);
      endfunction

      function void open_poll();
         add_result(KIND_RELEASE, '0, 1'b0, '0);
         add_result(KIND_SPI, OP_RDSR, 1'b0, '0);
         add_result(KIND_SPI, FILL_BYTE, 1'b1, '0);
      endfunction

      function void take_request(sfcs_req_type r);
         int unsigned  mark;
         bit           taken;
         sfcs_rsp_type tail;
         mark  = frames_due.size();
         taken = 1'b1;
         case (mode)
            MODE_IDLE: begin
               case (r.req_type)
                  REQ_READ_ID: begin
                     id_value = '0;
                     id_seen  = '0;
                     add_result(KIND_SPI, OP_RDID, 1'b0, '0);
                     add_result(KIND_SPI, FILL_BYTE, 1'b1, '0);
                     mode = MODE_ID_REPLY;
                  end
                  REQ_ERASE: begin
                     add_result(KIND_SPI, OP_WREN, 1'b0, '0);
                     add_result(KIND_RELEASE, '0, 1'b0, '0);
                     add_result(KIND_SPI, OP_ERASE, 1'b0, '0);
                     add_address(r.address);
                     open_poll();
                     mode = MODE_ERASE_POLL;
                  end
                  REQ_WRITE_START: begin
                     if (r.count == 0) begin
                        add_result(KIND_DONE, '0, 1'b0, '0);
                     end else begin
                        cursor     = r.address;
                        remaining  = r.count;
                        frame_open = 1'b0;
                        mode       = MODE_WRITE_DATA;
                     end
                  end
                  REQ_READ_START: begin
                     add_result(KIND_SPI, OP_READ, 1'b0, '0);
                     add_address(r.address);
                     if (r.count == 0) begin
                        add_result(KIND_RELEASE, '0, 1'b0, '0);
                        add_result(KIND_DONE, '0, 1'b0, '0);
                     end else begin
                        cursor    = r.address;
                        remaining = r.count;
                        add_result(KIND_SPI, FILL_BYTE, 1'b1, '0);
                        mode = MODE_READ_REPLY;
                     end
                  end
                  default: taken = 1'b0;
               endcase
            end
            MODE_WRITE_DATA: begin
               if (r.req_type != REQ_WRITE_DATA) begin
                  taken = 1'b0;
               end else begin
                  if (!frame_open) begin
                     add_result(KIND_SPI, OP_WREN, 1'b0, '0);
                     add_result(KIND_RELEASE, '0, 1'b0, '0);
                     add_result(KIND_SPI, OP_PROG, 1'b0, '0);
                     add_address(cursor);
                     frame_open = 1'b1;
                  end
                  add_result(KIND_SPI, r.data_byte, 1'b0, '0);
                  cursor    = cursor + 24'd1;
                  remaining = remaining - 16'd1;
                  if (remaining == 0 || (cursor % PAGE_BYTES) == 0) begin
                     open_poll();
                     frame_open = 1'b0;
                     mode       = MODE_WRITE_POLL;
                  end
               end
            end
            MODE_ID_REPLY: begin
               if (r.req_type != REQ_RX_BYTE) begin
                  taken = 1'b0;
               end else begin
                  id_value = {id_value[15:0], r.data_byte};
                  id_seen  = id_seen + 2'd1;
                  if (id_seen < 2'd3) begin
                     add_result(KIND_SPI, FILL_BYTE, 1'b1, '0);
                  end else begin
                     add_result(KIND_RELEASE, '0, 1'b0, '0);
                     add_result(KIND_HOST, '0, 1'b0, id_value);
                     add_result(KIND_DONE, '0, 1'b0, '0);
                     mode = MODE_IDLE;
                  end
               end
            end
            MODE_ERASE_POLL, MODE_WRITE_POLL: begin
               if (r.req_type != REQ_RX_BYTE) begin
                  taken = 1'b0;
               end else if ((r.data_byte & BUSY_MASK) != 0) begin
                  add_result(KIND_SPI, FILL_BYTE, 1'b1, '0);
               end else begin
                  add_result(KIND_RELEASE, '0, 1'b0, '0);
                  if (mode == MODE_WRITE_POLL && remaining != 0) begin
                     mode = MODE_WRITE_DATA;
                  end else begin
                     add_result(KIND_DONE, '0, 1'b0, '0);
                     mode = MODE_IDLE;
                  end
               end
            end
            MODE_READ_REPLY: begin
               if (r.req_type != REQ_RX_BYTE) begin
                  taken = 1'b0;
               end else begin
                  add_result(KIND_HOST, '0, 1'b0, {16'h0000, r.data_byte});
                  cursor    = cursor + 24'd1;
                  remaining = remaining - 16'd1;
                  if (remaining != 0) begin
                     add_result(KIND_SPI, FILL_BYTE, 1'b1, '0);
                  end else begin
                     add_result(KIND_RELEASE, '0, 1'b0, '0);
                     add_result(KIND_DONE, '0, 1'b0, '0);
                     mode = MODE_IDLE;
                  end
               end
            end
            default: taken = 1'b0;
         endcase
         if (!taken) begin
            add_result(KIND_REJECT, '0, 1'b0, '0);
         end
         if (frames_due.size() > mark) begin
            tail      = frames_due.pop_back();
            tail.last = 1'b1;
            frames_due.push_back(tail);
         end
      endfunction

      function void check_response(sfcs_rsp_type got);
         sfcs_rsp_type want;
         if (frames_due.size() == 0) begin
            $error("unexpected result item, kind %0d", got.kind);
            fault_count++;
         end else begin
            want = frames_due.pop_front();
            if (got.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, got.kind);
               fault_count++;
            end
            if (got.spi_byte !== want.spi_byte) begin
               $error("spi_byte: expected %02h, actual %02h", want.spi_byte, got.spi_byte);
               fault_count++;
            end
            if (got.need_reply !== want.need_reply) begin
               $error("need_reply: expected %0d, actual %0d", want.need_reply,
                      got.need_reply);
               fault_count++;
            end
            if (got.host_data !== want.host_data) begin
               $error("host_data: expected %06h, actual %06h", want.host_data,
                      got.host_data);
               fault_count++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, got.last);
               fault_count++;
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   sfcs_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   sfcs_rsp_type rsp_data;

   flash_frame_board board = new;
   bit               quiet_stretch = 1'b0;
   int               idle_cycles = 0;

   spi_nor_flash_command_sequencer_unit #(
      .PAGE_BYTES(PAGE_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned pick;
      if (quiet_stretch) begin
         return 0;
      end
      pick = $urandom_range(99, 0);
      if (pick < 60) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 8);
   endfunction

   function automatic sfcs_req_type next_request();
      sfcs_req_type r;
      int unsigned  pick;
      r.req_type  = REQ_RX_BYTE;
      r.address   = 24'($urandom);
      r.count     = 16'($urandom);
      r.data_byte = 8'($urandom);
      if ($urandom_range(9, 0) == 0) begin
         if (board.mode == MODE_IDLE) begin
            case ($urandom_range(3, 0))
               0: r.req_type = REQ_WRITE_DATA;
               1: r.req_type = REQ_RX_BYTE;
               2: r.req_type = REQ_SPARE_LOW;
               default: r.req_type = REQ_SPARE_HIGH;
            endcase
         end else begin
            r.req_type = 3'($urandom_range(7, 0));
         end
         return r;
      end
      case (board.mode)
         MODE_IDLE: begin
            case ($urandom_range(3, 0))
               0: r.req_type = REQ_READ_ID;
               1: r.req_type = REQ_ERASE;
               2: begin
                  r.req_type = REQ_WRITE_START;
                  case ($urandom_range(2, 0))
                     0: r.address = 24'($urandom);
                     1: r.address = (24'($urandom) & ~24'(PAGE_BYTES - 1))
                                    + 24'(PAGE_BYTES - $urandom_range(8, 1));
                     default: r.address = 24'hFFFFFF - 24'($urandom_range(6, 0));
                  endcase
                  pick = $urandom_range(99, 0);
                  if (pick < 5) begin
                     r.count = '0;
                  end else if (pick < 85) begin
                     r.count = 16'($urandom_range(8, 1));
                  end else begin
                     r.count = 16'($urandom_range(40, 9));
                  end
               end
               default: begin
                  r.req_type = REQ_READ_START;
                  r.count    = ($urandom_range(99, 0) < 8) ? '0 : 16'($urandom_range(6, 1));
               end
            endcase
         end
         MODE_WRITE_DATA: r.req_type = REQ_WRITE_DATA;
         MODE_ERASE_POLL, MODE_WRITE_POLL: r.data_byte[0] = ($urandom_range(2, 0) == 0);
         default: ;
      endcase
      return r;
   endfunction

   task automatic hold_off(input int unsigned cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic send_request(input sfcs_req_type item);
      hold_off(pick_gap());
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.take_request(item);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [2:0] code, input logic [23:0] addr,
                              input logic [15:0] cnt, input logic [7:0] value);
      sfcs_req_type item;
      item.req_type  = code;
      item.address   = addr;
      item.count     = cnt;
      item.data_byte = value;
      send_request(item);
   endtask

   task automatic settle_results();
      req_valid <= 1'b0;
      while (board.frames_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int unsigned hold;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(6, 1) - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_spi_nor_flash_command_sequencer_unit failed");
         $finish;
      end
   end

   initial begin
      int sent;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'hFF);
      send_fields(REQ_SPARE_LOW, 24'h123456, 16'h0001, 8'h00);
      send_fields(REQ_SPARE_HIGH, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      send_fields(REQ_READ_ID, 24'h000000, 16'h0000, 8'h00);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'hFF);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'h00);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'hA5);
      send_fields(REQ_ERASE, 24'hFFFFFF, 16'h0000, 8'h00);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'h01);
      send_fields(REQ_READ_ID, 24'h000000, 16'h0000, 8'h00);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'h00);
      send_fields(REQ_WRITE_START, 24'h00ABCD, 16'h0000, 8'h00);
      send_fields(REQ_READ_START, 24'h000000, 16'h0000, 8'h00);
      send_fields(REQ_WRITE_START, 24'hFFFFFE, 16'h0003, 8'h00);
      send_fields(REQ_WRITE_DATA, 24'h000000, 16'h0000, 8'h00);
      send_fields(REQ_WRITE_DATA, 24'h000000, 16'h0000, 8'hFF);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'hFF);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'hFE);
      send_fields(REQ_WRITE_DATA, 24'h000000, 16'h0000, 8'h5A);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'h00);
      send_fields(REQ_READ_START, 24'hFFFFFF, 16'h0002, 8'h00);
      send_fields(REQ_WRITE_START, 24'hFFFFFF, 16'hFFFF, 8'hFF);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'h00);
      send_fields(REQ_RX_BYTE, 24'h000000, 16'h0000, 8'hFF);
      settle_results();

      for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
         if ($urandom_range(59, 0) == 0) begin
            quiet_stretch = !quiet_stretch;
         end
         if ($urandom_range(79, 0) == 0) begin
            settle_results();
         end
         send_request(next_request());
      end

      settle_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.fault_count == 0 && board.frames_due.size() == 0) begin
         $display("tb_spi_nor_flash_command_sequencer_unit passed");
      end else begin
         $display("tb_spi_nor_flash_command_sequencer_unit failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/sfcs_pkg.sv
design/sfcs_front.sv
design/sfcs_queue.sv
design/sfcs_back.sv
design/spi_nor_flash_command_sequencer_unit.sv
tb/sv/tb_spi_nor_flash_command_sequencer_unit.sv
